@@ hw/rtl/sf5_pkg.sv @@
// ----------------------------------------------------------------------------
// sf5_pkg
// shared types and constants of the 5x5 sharpening filter
// ----------------------------------------------------------------------------
package sf5_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 11'd480;
    localparam logic [CFG_DATA_W-1:0] MIN_SIZE     = 11'd3;

    // floor(x / 25) = (x * DIV_MUL) >> DIV_SHIFT for x below 43690
    localparam logic [13:0] DIV_MUL   = 14'd10486;
    localparam int          DIV_SHIFT = 18;

    // 5x5 neighbourhood, indexed [row][column]
    typedef logic [4:0][4:0][7:0] win_t;

    typedef struct packed {
        logic frame_done;
        logic run_last;
    } res_flags_t;

    typedef struct packed {
        win_t       tap;
        res_flags_t flags;
    } tap_item_t;

endpackage

@@ hw/rtl/sharpen_filter_5x5.sv @@
// ----------------------------------------------------------------------------
// sharpen_filter_5x5
// 5x5 sharpening filter over a raster pixel stream with mirrored borders
// ----------------------------------------------------------------------------
// Takes one pixel item per cycle unless stalled. The four previous lines sit
// packed in one line ram (one word of four pixels per column). The word is
// read at the arriving column and written back when the pixel leaves the
// first stage. Results pass the stage registers of sf5_arith once the window
// is loaded into the result sequencer, which issues one result per cycle
// unless the output stalls. An input in the last row causes three results,
// so inputs from the fourth column of that row on are held. The three results
// of a last column and the nine of the final pixel finish while the first two
// columns (or rows) that follow pass through; those cause no results, so no
// input cycles are lost. An output stall freezes the result pipeline and, once
// the sequencer and the first stage are full, the input. Results lag the
// input by two rows and two columns. A write of frame_width or frame_height
// restarts the frame.
module sharpen_filter_5x5 #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [7:0]                         pixel_in,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [8:0]                  pixel_out,
    output logic                               frame_done,
    output logic                               run_last,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sf5_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sf5_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ROW_W = $clog2(MAX_ROWS);

    logic [sf5_pkg::CFG_DATA_W-1:0] frame_width_reg;
    logic [sf5_pkg::CFG_DATA_W-1:0] frame_height_reg;
    logic [COL_W:0]                 w_lim;
    logic [ROW_W:0]                 h_lim;

    logic [ROW_W-1:0]               row_reg;
    logic [COL_W-1:0]               col_reg;
    logic                           col_end;
    logic                           row_end;
    logic                           accept;
    logic                           cfg_write;
    logic                           cfg_hit;

    logic                           s1_valid_reg;
    logic [7:0]                     s1_pix_reg;
    logic [ROW_W-1:0]               s1_row_reg;
    logic [COL_W-1:0]               s1_col_reg;
    logic                           s1_emit_reg;
    logic                           s1_last_row_reg;
    logic                           s1_last_col_reg;
    logic                           s1_move;

    logic [31:0]                    ram_rd;
    logic [31:0]                    ram_wr;
    logic [4:0][7:0]                col_vec;
    sf5_pkg::win_t                  win_reg;
    sf5_pkg::win_t                  win_next;

    logic                           job_ready;
    logic                           adv;
    logic                           tap_valid;
    sf5_pkg::tap_item_t             tap_item;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign cfg_hit   = (cfg_index == sf5_pkg::REG_FRAME_WIDTH)
                    || (cfg_index == sf5_pkg::REG_FRAME_HEIGHT);

    always_comb
    begin
        if (frame_width_reg < sf5_pkg::MIN_SIZE)
        begin
            w_lim = (COL_W+1)'(sf5_pkg::MIN_SIZE);
        end
        else if (32'(frame_width_reg) > 32'(MAX_COLS))
        begin
            w_lim = (COL_W+1)'(MAX_COLS);
        end
        else
        begin
            w_lim = (COL_W+1)'(frame_width_reg);
        end
        if (frame_height_reg < sf5_pkg::MIN_SIZE)
        begin
            h_lim = (ROW_W+1)'(sf5_pkg::MIN_SIZE);
        end
        else if (32'(frame_height_reg) > 32'(MAX_ROWS))
        begin
            h_lim = (ROW_W+1)'(MAX_ROWS);
        end
        else
        begin
            h_lim = (ROW_W+1)'(frame_height_reg);
        end
    end

    assign col_end  = (COL_W+1)'(col_reg) == w_lim - (COL_W+1)'(1);
    assign row_end  = (ROW_W+1)'(row_reg) == h_lim - (ROW_W+1)'(1);
    assign s1_move  = s1_valid_reg && (!s1_emit_reg || job_ready);
    assign in_stall = s1_valid_reg && !s1_move;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= sf5_pkg::WIDTH_RESET;
            frame_height_reg <= sf5_pkg::HEIGHT_RESET;
            row_reg          <= '0;
            col_reg          <= '0;
            s1_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write && cfg_index == sf5_pkg::REG_FRAME_WIDTH)
            begin
                frame_width_reg <= cfg_data;
            end
            if (cfg_write && cfg_index == sf5_pkg::REG_FRAME_HEIGHT)
            begin
                frame_height_reg <= cfg_data;
            end
            if (cfg_write && cfg_hit)
            begin
                row_reg <= '0;
                col_reg <= '0;
            end
            else if (accept)
            begin
                if (col_end)
                begin
                    col_reg <= '0;
                    row_reg <= row_end ? '0 : row_reg + ROW_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + COL_W'(1);
                end
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg      <= pixel_in;
            s1_row_reg      <= row_reg;
            s1_col_reg      <= col_reg;
            s1_emit_reg     <= (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2));
            s1_last_row_reg <= row_end;
            s1_last_col_reg <= col_end;
        end
        if (s1_move)
        begin
            win_reg <= win_next;
        end
    end

    sf5_ram #(
        .WIDTH (32),
        .DEPTH (MAX_COLS)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (s1_move),
        .wr_addr (s1_col_reg),
        .wr_data (ram_wr),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (ram_rd)
    );

    // column of rows r-4 .. r; row r-4 shares its slot with the new pixel
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            col_vec[k] = ram_rd[8*(2'(s1_row_reg[1:0] + 2'(k))) +: 8];
        end
        col_vec[4] = s1_pix_reg;
        ram_wr = ram_rd;
        ram_wr[8*s1_row_reg[1:0] +: 8] = s1_pix_reg;
        for (int r = 0; r < 5; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                win_next[r][c] = win_reg[r][c+1];
            end
            win_next[r][4] = col_vec[r];
        end
    end

    sf5_emit #(
        .ROW_W (ROW_W),
        .COL_W (COL_W)
    ) u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (s1_move && s1_emit_reg),
        .load_win      (win_next),
        .load_row      (s1_row_reg),
        .load_col      (s1_col_reg),
        .load_last_row (s1_last_row_reg),
        .load_last_col (s1_last_col_reg),
        .h             (h_lim),
        .w             (w_lim),
        .adv           (adv),
        .job_ready     (job_ready),
        .tap_valid     (tap_valid),
        .tap_item      (tap_item)
    );

    sf5_arith u_arith (
        .clk        (clk),
        .rst_n      (rst_n),
        .tap_valid  (tap_valid),
        .tap_item   (tap_item),
        .adv        (adv),
        .stall      (out_stall),
        .valid      (out_valid),
        .pixel_out  (pixel_out),
        .frame_done (frame_done),
        .run_last   (run_last)
    );

`ifndef SYNTHESIS
    a_job_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && s1_emit_reg) |-> job_ready)
        else $error("window loaded into busy result sequencer");

    a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        ((COL_W+1)'(col_reg) < w_lim) && ((ROW_W+1)'(row_reg) < h_lim))
        else $error("position counter outside frame");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_done) |-> run_last)
        else $error("frame end not on last result of its input");
`endif

endmodule

@@ hw/rtl/sf5_ram.sv @@
// ----------------------------------------------------------------------------
// sf5_ram
// generic single-write, single-read synchronous ram with registered read
// ----------------------------------------------------------------------------
module sf5_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hw/rtl/sf5_emit.sv @@
// ----------------------------------------------------------------------------
// sf5_emit
// result sequencer: holds one input's window and issues its results, one per
// cycle while adv is high, with the mirrored 5x5 taps of each output position
// ----------------------------------------------------------------------------
module sf5_emit #(
    parameter int ROW_W = 10,
    parameter int COL_W = 10
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  sf5_pkg::win_t          load_win,
    input  logic [ROW_W-1:0]       load_row,
    input  logic [COL_W-1:0]       load_col,
    input  logic                   load_last_row,
    input  logic                   load_last_col,
    input  logic [ROW_W:0]         h,
    input  logic [COL_W:0]         w,
    input  logic                   adv,
    output logic                   job_ready,
    output logic                   tap_valid,
    output sf5_pkg::tap_item_t     tap_item
);

    logic                  valid_reg;
    sf5_pkg::win_t         win_reg;
    logic [ROW_W-1:0]      row_reg;
    logic [COL_W-1:0]      col_reg;
    logic                  last_row_reg;
    logic                  last_col_reg;
    logic [1:0]            dr_reg;
    logic [1:0]            dc_reg;

    logic                  end_col;
    logic                  end_row;
    logic                  job_last;
    logic                  fire;

    logic signed [ROW_W+2:0] rr [5];
    logic signed [COL_W+2:0] cc [5];
    logic [2:0]              rsel [5];
    logic [2:0]              csel [5];

    assign end_col   = !last_col_reg || (dc_reg == 2'd2);
    assign end_row   = !last_row_reg || (dr_reg == 2'd2);
    assign job_last  = end_col && end_row;
    assign fire      = valid_reg && adv;
    assign job_ready = !valid_reg || (adv && job_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            dr_reg    <= 2'd0;
            dc_reg    <= 2'd0;
        end
        else
        begin
            if (load && job_ready)
            begin
                valid_reg <= 1'b1;
                dr_reg    <= 2'd0;
                dc_reg    <= 2'd0;
            end
            else if (fire)
            begin
                if (job_last)
                begin
                    valid_reg <= 1'b0;
                end
                else if (end_col)
                begin
                    dc_reg <= 2'd0;
                    dr_reg <= dr_reg + 2'd1;
                end
                else
                begin
                    dc_reg <= dc_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && job_ready)
        begin
            win_reg      <= load_win;
            row_reg      <= load_row;
            col_reg      <= load_col;
            last_row_reg <= load_last_row;
            last_col_reg <= load_last_col;
        end
    end

    // mirrored row and column of each tap, as a window index
    always_comb
    begin
        for (int m = 0; m < 5; m++)
        begin
            rr[m] = $signed((ROW_W+3)'(row_reg) + (ROW_W+3)'(dr_reg) + (ROW_W+3)'(m))
                    - $signed((ROW_W+3)'(4));
            if (rr[m] < 0)
            begin
                rr[m] = -rr[m];
            end
            if (rr[m] >= $signed((ROW_W+3)'(h)))
            begin
                rr[m] = $signed((ROW_W+3)'(h) + (ROW_W+3)'(h)) - $signed((ROW_W+3)'(2))
                        - rr[m];
            end
            rsel[m] = 3'(rr[m] - $signed((ROW_W+3)'(row_reg)) + $signed((ROW_W+3)'(4)));

            cc[m] = $signed((COL_W+3)'(col_reg) + (COL_W+3)'(dc_reg) + (COL_W+3)'(m))
                    - $signed((COL_W+3)'(4));
            if (cc[m] < 0)
            begin
                cc[m] = -cc[m];
            end
            if (cc[m] >= $signed((COL_W+3)'(w)))
            begin
                cc[m] = $signed((COL_W+3)'(w) + (COL_W+3)'(w)) - $signed((COL_W+3)'(2))
                        - cc[m];
            end
            csel[m] = 3'(cc[m] - $signed((COL_W+3)'(col_reg)) + $signed((COL_W+3)'(4)));
        end
    end

    always_comb
    begin
        for (int m = 0; m < 5; m++)
        begin
            for (int n = 0; n < 5; n++)
            begin
                tap_item.tap[m][n] = win_reg[rsel[m]][csel[n]];
            end
        end
        tap_item.flags.frame_done = last_row_reg && last_col_reg
                                    && (dr_reg == 2'd2) && (dc_reg == 2'd2);
        tap_item.flags.run_last   = job_last;
    end

    assign tap_valid = valid_reg;

endmodule

@@ hw/rtl/sf5_arith.sv @@
// ----------------------------------------------------------------------------
// sf5_arith
// kernel sum and divide-by-25 pipeline with the output register
// ----------------------------------------------------------------------------
module sf5_arith (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 tap_valid,
    input  sf5_pkg::tap_item_t   tap_item,
    output logic                 adv,
    input  logic                 stall,
    output logic                 valid,
    output logic signed [8:0]    pixel_out,
    output logic                 frame_done,
    output logic                 run_last
);

    logic                 a_valid_reg;
    sf5_pkg::tap_item_t   a_item_reg;

    logic                 b_valid_reg;
    logic [10:0]          b_sum_reg [5];
    logic [7:0]           b_center_reg;
    sf5_pkg::res_flags_t  b_flags_reg;
    logic [10:0]          b_sum_next [5];

    logic                 c_valid_reg;
    logic [12:0]          c_total_reg;
    logic [12:0]          c_center26_reg;
    sf5_pkg::res_flags_t  c_flags_reg;

    logic                 d_valid_reg;
    logic [12:0]          d_abs_reg;
    logic                 d_neg_reg;
    sf5_pkg::res_flags_t  d_flags_reg;
    logic signed [14:0]   d_val_next;

    logic                 e_valid_reg;
    logic [26:0]          e_prod_reg;
    logic                 e_neg_reg;
    sf5_pkg::res_flags_t  e_flags_reg;

    logic                 out_valid_reg;
    logic signed [8:0]    out_pixel_reg;
    sf5_pkg::res_flags_t  out_flags_reg;
    logic [8:0]           quot;

    assign adv = !(out_valid_reg && stall);

    always_comb
    begin
        for (int r = 0; r < 5; r++)
        begin
            b_sum_next[r] = 11'(a_item_reg.tap[r][0]) + 11'(a_item_reg.tap[r][1])
                          + 11'(a_item_reg.tap[r][2]) + 11'(a_item_reg.tap[r][3])
                          + 11'(a_item_reg.tap[r][4]);
        end
    end

    // 25 * center minus the other 24 taps
    assign d_val_next = $signed({2'b00, c_center26_reg}) - $signed({2'b00, c_total_reg});
    assign quot       = e_prod_reg[sf5_pkg::DIV_SHIFT +: 9];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            e_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg   <= tap_valid;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            d_valid_reg   <= c_valid_reg;
            e_valid_reg   <= d_valid_reg;
            out_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_item_reg <= tap_item;

            b_sum_reg    <= b_sum_next;
            b_center_reg <= a_item_reg.tap[2][2];
            b_flags_reg  <= a_item_reg.flags;

            c_total_reg    <= 13'(b_sum_reg[0]) + 13'(b_sum_reg[1]) + 13'(b_sum_reg[2])
                            + 13'(b_sum_reg[3]) + 13'(b_sum_reg[4]);
            c_center26_reg <= {1'b0, b_center_reg, 4'b0000} + {2'b00, b_center_reg, 3'b000}
                            + {4'b0000, b_center_reg, 1'b0};
            c_flags_reg    <= b_flags_reg;

            d_neg_reg   <= d_val_next < 0;
            d_abs_reg   <= (d_val_next < 0) ? 13'(-d_val_next) : 13'(d_val_next);
            d_flags_reg <= c_flags_reg;

            e_prod_reg  <= 27'(d_abs_reg) * 27'(sf5_pkg::DIV_MUL);
            e_neg_reg   <= d_neg_reg;
            e_flags_reg <= d_flags_reg;

            out_pixel_reg <= e_neg_reg ? $signed(-quot) : $signed(quot);
            out_flags_reg <= e_flags_reg;
        end
    end

    assign valid      = out_valid_reg;
    assign pixel_out  = out_pixel_reg;
    assign frame_done = out_flags_reg.frame_done;
    assign run_last   = out_flags_reg.run_last;

endmodule

@@ verif/sharpen_filter_5x5_checker.sv @@
// ----------------------------------------------------------------------------
// sharpen_filter_5x5_checker
// predicts and checks the sharpened pixel stream of sharpen_filter_5x5
// ----------------------------------------------------------------------------
// Watches the configuration, pixel and result channels. Every accepted pixel
// is stored in a private copy of the four line stores. The 5x5 sharpening sum
// is then worked out for every position that has become complete, with the
// mirrored borders. Results are compared field by field, in order, with the
// oldest expected value. Mismatches go to a failure count for the top.
// ----------------------------------------------------------------------------
module sharpen_filter_5x5_checker #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [7:0]                     pixel_in,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic signed [8:0]              pixel_out,
    input  logic                           frame_done,
    input  logic                           run_last,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [sf5_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sf5_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             errors,
    output int                             pending
);

    typedef struct packed {
        logic signed [8:0] pixel;
        logic              frame_done;
        logic              run_last;
    } sharp_res_t;

    sharp_res_t                     sharp_q[$];
    logic [7:0]                     line_mem [4*MAX_COLS];
    logic [7:0]                     displaced [5];
    int                             row_pos;
    int                             col_pos;
    logic [sf5_pkg::CFG_DATA_W-1:0] width_reg;
    logic [sf5_pkg::CFG_DATA_W-1:0] height_reg;

    initial
    begin
        errors  = 0;
        pending = 0;
        foreach (line_mem[i]) line_mem[i] = 8'd0;
    end

    function automatic int clip_size(int v, int hi);
        if (v < 3) return 3;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int reflect(int i, int n);
        if (i < 0) i = -i;
        if (i >= n) i = 2 * (n - 1) - i;
        return i;
    endfunction

    function automatic int tap_at(int r, int c, int ri, int ci);
        if (r + 4 == ri && c + 4 >= ci && c <= ci)
            return displaced[ci - c];
        return line_mem[(r & 3) * MAX_COLS + c];
    endfunction

    function automatic logic signed [8:0] sharpen_at(int ro, int co, int ri, int ci,
                                                     int w, int h);
        int acc;
        int p;
        int q;
        acc = 0;
        for (int m = -2; m <= 2; m++)
        begin
            for (int n = -2; n <= 2; n++)
            begin
                p = tap_at(reflect(ro + m, h), reflect(co + n, w), ri, ci);
                acc += (m == 0 && n == 0) ? 25 * p : -p;
            end
        end
        q = acc / 25;
        return q[8:0];
    endfunction

    task automatic take_pixel(input logic [7:0] v);
        int w;
        int h;
        int ri;
        int ci;
        int idx;
        int r1;
        int c1;
        sharp_res_t res;
        w  = clip_size(int'(width_reg), MAX_COLS);
        h  = clip_size(int'(height_reg), MAX_ROWS);
        ri = (row_pos >= h) ? h - 1 : row_pos;
        ci = (col_pos >= w) ? w - 1 : col_pos;
        idx = (ri & 3) * MAX_COLS + ci;
        for (int k = 4; k > 0; k--) displaced[k] = displaced[k-1];
        displaced[0] = line_mem[idx];
        line_mem[idx] = v;
        if (ri >= 2 && ci >= 2)
        begin
            r1 = (ri == h - 1) ? h - 1 : ri - 2;
            c1 = (ci == w - 1) ? w - 1 : ci - 2;
            for (int ro = ri - 2; ro <= r1; ro++)
            begin
                for (int co = ci - 2; co <= c1; co++)
                begin
                    res.pixel      = sharpen_at(ro, co, ri, ci, w, h);
                    res.frame_done = (ro == h - 1 && co == w - 1);
                    res.run_last   = (ro == r1 && co == c1);
                    sharp_q.push_back(res);
                end
            end
        end
        ci++;
        if (ci >= w)
        begin
            ci = 0;
            ri++;
            if (ri >= h) ri = 0;
        end
        row_pos = ri;
        col_pos = ci;
    endtask

    always @(posedge clk)
    begin
        sharp_res_t exp_res;
        if (!rst_n)
        begin
            sharp_q.delete();
            foreach (displaced[k]) displaced[k] = 8'd0;
            row_pos    = 0;
            col_pos    = 0;
            width_reg  = sf5_pkg::WIDTH_RESET;
            height_reg = sf5_pkg::HEIGHT_RESET;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (sharp_q.size() == 0)
                begin
                    $error("result with no item expected: pixel_out %0d", pixel_out);
                    errors++;
                end
                else
                begin
                    exp_res = sharp_q.pop_front();
                    if (pixel_out !== exp_res.pixel)
                    begin
                        $error("pixel_out expected %0d actual %0d", exp_res.pixel, pixel_out);
                        errors++;
                    end
                    if (frame_done !== exp_res.frame_done)
                    begin
                        $error("frame_done expected %0b actual %0b",
                               exp_res.frame_done, frame_done);
                        errors++;
                    end
                    if (run_last !== exp_res.run_last)
                    begin
                        $error("run_last expected %0b actual %0b", exp_res.run_last, run_last);
                        errors++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == sf5_pkg::REG_FRAME_WIDTH)
                begin
                    width_reg = cfg_data;
                    row_pos   = 0;
                    col_pos   = 0;
                end
                else if (cfg_index == sf5_pkg::REG_FRAME_HEIGHT)
                begin
                    height_reg = cfg_data;
                    row_pos    = 0;
                    col_pos    = 0;
                end
            end
            if (in_valid && !in_stall)
                take_pixel(pixel_in);
        end
        pending = sharp_q.size();
    end

endmodule

@@ verif/sharpen_filter_5x5_test.sv @@
// ----------------------------------------------------------------------------
// sharpen_filter_5x5_test
// stimulus and verdict for the 5x5 sharpening filter
// ----------------------------------------------------------------------------
// Drives small pixel frames of several sizes into the filter, including sizes
// below the minimum and above the maximum, mostly with random pixels. Sender
// gaps and receiver stalls vary by phase, and one long receiver hold-off
// fills the pipeline. Checking is done by the checker beside the dut.
// ----------------------------------------------------------------------------
module sharpen_filter_5x5_test;

    localparam logic [sf5_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd2;
    localparam int IDLE_LIMIT = 5000;
    localparam int LONG_HOLD  = 300;

    logic                           clk;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_stall;
    logic [7:0]                     pixel_in  = 8'd0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic signed [8:0]              pixel_out;
    logic                           frame_done;
    logic                           run_last;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [sf5_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [sf5_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    int                             errors;
    int                             pending;
    int                             gap_pct   = 0;
    int                             stall_pct = 0;
    logic                           hold_go   = 1'b0;
    int                             hold_cnt  = 0;
    logic                           hold_done = 1'b0;
    int                             idle_cycles = 0;

    sharpen_filter_5x5 dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .pixel_in(pixel_in),
        .out_valid(out_valid), .out_stall(out_stall), .pixel_out(pixel_out),
        .frame_done(frame_done), .run_last(run_last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    sharpen_filter_5x5_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .pixel_in(pixel_in),
        .out_valid(out_valid), .out_stall(out_stall), .pixel_out(pixel_out),
        .frame_done(frame_done), .run_last(run_last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // receiver stalls, with one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_go && !hold_done)
        begin
            hold_cnt  = LONG_HOLD;
            hold_done = 1'b1;
        end
        if (hold_cnt > 0)
        begin
            out_stall <= 1'b1;
            hold_cnt--;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic set_mode(input int m);
        case (m)
            0:       begin gap_pct = 0;  stall_pct = 0;  end
            1:       begin gap_pct = 58; stall_pct = 0;  end
            2:       begin gap_pct = 0;  stall_pct = 58; end
            default: begin gap_pct = 11; stall_pct = 11; end
        endcase
    endtask

    task automatic offer_pixel(input logic [7:0] v);
        in_valid <= 1'b0;
        while (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) @(posedge clk);
        in_valid <= 1'b1;
        pixel_in <= v;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic offer_random(input int n);
        for (int i = 0; i < n; i++) offer_pixel(8'($urandom_range(0, 255)));
        in_valid <= 1'b0;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [sf5_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sf5_pkg::CFG_DATA_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int w;
        int h;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bright center, then dark center on a flat bright field
        write_reg(sf5_pkg::REG_FRAME_WIDTH, 11'd3);
        write_reg(sf5_pkg::REG_FRAME_HEIGHT, 11'd3);
        for (int i = 0; i < 9; i++) offer_pixel((i == 4) ? 8'd255 : 8'd0);
        for (int i = 0; i < 9; i++) offer_pixel((i == 4) ? 8'd0 : 8'd255);
        drain();

        // sizes below the minimum and an unused index
        write_reg(sf5_pkg::REG_FRAME_WIDTH, 11'd2);
        write_reg(sf5_pkg::REG_FRAME_HEIGHT, 11'd0);
        write_reg(REG_UNUSED, 11'($urandom));
        offer_random(9);
        drain();

        // width beyond the maximum
        write_reg(sf5_pkg::REG_FRAME_WIDTH, 11'd2047);
        write_reg(sf5_pkg::REG_FRAME_HEIGHT, 11'd3);
        offer_random(9);
        drain();

        // height beyond the maximum
        write_reg(sf5_pkg::REG_FRAME_WIDTH, 11'd3);
        write_reg(sf5_pkg::REG_FRAME_HEIGHT, 11'd2047);
        offer_random(9);
        drain();

        for (int p = 0; p < 4; p++)
        begin
            set_mode(p);
            if (p == 0)
            begin
                w = 5;
                h = 4;
            end
            else
            begin
                w = $urandom_range(3, 5);
                h = $urandom_range(3, 4);
            end
            write_reg(sf5_pkg::REG_FRAME_WIDTH, 11'(w));
            write_reg(sf5_pkg::REG_FRAME_HEIGHT, 11'(h));
            if (p == 0) hold_go <= 1'b1;
            offer_random(w * h + $urandom_range(0, w));
            drain();
        end

        if (errors == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
